### rtl/fqbps_pkg.sv
// ----------------------------------------------------------------------------
// fqbps_pkg: shared definitions for the floor-quotient block power sum
// Widths, constants and the request and response records of the divider.
// ----------------------------------------------------------------------------
package fqbps_pkg;

  // Width of the limit field; only these bits of the input are used.
  localparam int LIMIT_BITS = 20;
  // The square-root search tries root bits from (LIMIT_BITS + 1) / 2 down to 0.
  localparam int ROOT_BITS  = (LIMIT_BITS + 1) / 2 + 1;
  // Sums wrap modulo 2^TOTAL_W; the multiplier handles one half word a cycle.
  localparam int TOTAL_W    = 64;
  localparam int HALF_W     = TOTAL_W / 2;
  // Second multiplier operand: holds quotients, loop indexes and 2m+1.
  localparam int MB_W       = LIMIT_BITS + 1;
  localparam int PROD_W     = HALF_W + MB_W;
  localparam int DIV_CNT_W  = $clog2(LIMIT_BITS + 1);
  // The sum-of-squares closed form divides m(m+1)(2m+1) by six: by three
  // through a multiplication by the reciprocal rounded up, which is exact for
  // every limit-wide m once THIRD_SHIFT bits are dropped, and by two as a shift.
  localparam int THIRD_SHIFT  = LIMIT_BITS + 1;
  localparam int THIRD_RECIP  = (1 << THIRD_SHIFT) / 3 + 1;
  localparam int THIRD_PROD_W = 2 * LIMIT_BITS;

  typedef struct packed {
    logic                  start;
    logic [LIMIT_BITS-1:0] dividend;
    logic [ROOT_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [LIMIT_BITS-1:0] quo;
  } div_rsp_t;

endpackage

### rtl/fqbps_limit_if.sv
// ----------------------------------------------------------------------------
// fqbps_limit_if: input channel carrying one summation limit
// Valid/ready channel; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface fqbps_limit_if;
  import fqbps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

### rtl/fqbps_total_if.sv
// ----------------------------------------------------------------------------
// fqbps_total_if: output channel carrying one wrapped power sum
// Valid/ready channel; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface fqbps_total_if;
  import fqbps_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total;

  modport source (output valid, output total, input ready);
  modport sink   (input valid, input total, output ready);
endinterface

### rtl/fqbps_div.sv
// ----------------------------------------------------------------------------
// fqbps_div: shared restoring divider
// Divides a limit-wide dividend by a root-wide divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fqbps_div (
  input  logic                clk,
  input  logic                rst,
  input  fqbps_pkg::div_req_t req,
  output fqbps_pkg::div_rsp_t rsp
);
  import fqbps_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [LIMIT_BITS-1:0] num;
  logic [ROOT_BITS-1:0]  den;
  logic [ROOT_BITS-1:0]  rem;

  logic [ROOT_BITS:0]    trial;
  logic [ROOT_BITS:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem, num[LIMIT_BITS-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(LIMIT_BITS);
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        // The quotient bits shift in where the dividend bits leave.
        num <= {num[LIMIT_BITS-2:0], fits};
        rem <= fits ? diff[ROOT_BITS-1:0] : trial[ROOT_BITS-1:0];
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;

  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while a division is still running");

endmodule

### rtl/floor_quotient_block_power_sum.sv
// ----------------------------------------------------------------------------
// floor_quotient_block_power_sum: sum of x^2 * floor(n/x)^3 for x = 1..n
// Floor-quotient block method on one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel    role    payload                       transfer
//   --------   -----   ---------------------------   -------------------
//   limit_ch   sink    limit [19:0], unsigned n       valid && ready
//   total_ch   source  total [63:0], S mod 2^64       valid && ready
//
// Run time grows with s = floor(sqrt n) and with v = n / ceil(sqrt n); a
// perfect square adds a correction pass. A zero limit goes straight from
// idle to the done state. The divider (one quotient bit per cycle) and the
// multiplier (two half-word partial products per 64 x 21 bit product) set
// the run time.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// limit_ch.ready is high only while the sequencer is idle. A finished sum
// waits in the output register while the next limit is taken; if the next
// sum finishes before the first is taken, the sequencer holds in its done state.
//
// The work runs in phases:
//   1. The integer square root s is built one bit at a time, squaring each
//      trial value on the multiplier; a perfect square is noted on the way.
//   2. For x = 1..s the term x^2 * (n/x)^3 is accumulated.
//   3. v = n / c is found, with c = s on a perfect square and s + 1 otherwise.
//   4. For each quotient value i = 1..v the term i^3 * (P(n/i) - P(n/(i+1)))
//      is accumulated, with P(m) = m(m+1)(2m+1)/6. The previous P is kept, so
//      each step needs one new quotient. P finds m / 3 through a reciprocal
//      multiplication and divides by three the one of the three factors
//      that is a multiple of three, and halves the even factor, so the
//      product needs no division afterwards.
//   5. On a perfect square, s^5, which phases 2 and 4 both count, is removed.
// All products wrap modulo 2^64; a product of the 64-bit register and a
// 21-bit operand is formed from two half-word partial products.
// ----------------------------------------------------------------------------
module floor_quotient_block_power_sum (
  input  logic          clk,
  input  logic          rst,
  fqbps_limit_if.sink   limit_ch,
  fqbps_total_if.source total_ch
);
  import fqbps_pkg::*;

  localparam int BIDX_W = $clog2(ROOT_BITS);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_CMP,
    S_DIV_WAIT,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ADD,
    S_P1_DIV,
    S_P1_Q,
    S_P1_M2,
    S_P1_M3,
    S_P1_M4,
    S_P1_ACC,
    S_MX_DIV,
    S_MX_Q,
    S_P_DIV3,
    S_P_F,
    S_P_M2,
    S_P2_START,
    S_P2_DIV,
    S_P2_Q,
    S_P2_D,
    S_P2_M2,
    S_P2_M3,
    S_P2_ACC,
    S_FIX,
    S_FX_M2,
    S_FX_M3,
    S_FX_M4,
    S_FX_SUB,
    S_DONE
  } state_t;

  state_t                state;
  state_t                ret;      // where a division or product returns
  state_t                pret;     // where a sum-of-squares evaluation returns

  logic [LIMIT_BITS-1:0] n;
  logic [ROOT_BITS-1:0]  root;
  logic [BIDX_W-1:0]     bidx;
  logic                  perfect;
  logic [ROOT_BITS-1:0]  i;
  logic [LIMIT_BITS-1:0] maxv;
  logic [LIMIT_BITS-1:0] pm;       // argument of the sum of squares
  logic [LIMIT_BITS-1:0] p_quo;    // pm / 3
  logic [1:0]            p_rem;    // pm mod 3
  logic [TOTAL_W-1:0]    pprev;    // sum of squares of the previous quotient
  logic [TOTAL_W-1:0]    acc;
  logic [TOTAL_W-1:0]    ma;       // multiplicand and product register
  logic [MB_W-1:0]       mb;
  logic [TOTAL_W-1:0]    prod_lo;
  logic [HALF_W-1:0]     prod_hi;
  logic [TOTAL_W-1:0]    total;
  logic                  total_valid;

  logic [ROOT_BITS-1:0]    sq_try;
  logic [ROOT_BITS-1:0]    c_div;
  logic [HALF_W-1:0]       mul_x;
  logic [PROD_W-1:0]       mul_p;
  logic [THIRD_PROD_W-1:0] third_prod;
  logic [LIMIT_BITS-1:0]   third_q;
  logic [1:0]              third_r;
  logic [MB_W-1:0]         f0;
  logic [MB_W-1:0]         f1;
  logic [MB_W-1:0]         f2;
  logic [MB_W-1:0]         m_ext;
  logic [MB_W-1:0]         q_ext;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  fqbps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next trial root: the current root with the bit under test set.
  assign sq_try = root | (ROOT_BITS'(1) << bidx);
  // Smallest x whose quotient is handled by the quotient-value phase.
  assign c_div  = perfect ? root : root + ROOT_BITS'(1);

  // The single multiplier takes the low half of ma, then the high half.
  assign mul_x = (state == S_MUL_HI) ? ma[TOTAL_W-1:HALF_W] : ma[HALF_W-1:0];
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mb);

  // pm / 3 by the reciprocal rounded up; the remainder is what 3q leaves.
  assign third_prod = THIRD_PROD_W'(pm) * THIRD_PROD_W'(THIRD_RECIP);
  assign third_q    = LIMIT_BITS'(third_prod >> THIRD_SHIFT);
  assign third_r    = 2'(pm - ((third_q << 1) + third_q));

  // Factors of m(m+1)(2m+1) with the three and the two already divided out.
  // p_quo and p_rem hold pm / 3 and its remainder while these are read.
  always_comb begin
    m_ext = MB_W'(pm);
    q_ext = MB_W'(p_quo);
    f0 = (p_rem == 2'd0) ? q_ext : m_ext;
    f1 = (p_rem == 2'd2) ? q_ext + MB_W'(1) : m_ext + MB_W'(1);
    f2 = (p_rem == 2'd1) ? {q_ext[MB_W-2:0], 1'b1}
                         : {m_ext[MB_W-2:0], 1'b1};
    if (!pm[0]) begin
      f0 = f0 >> 1;
    end else begin
      f1 = f1 >> 1;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = n;
    div_req.divisor  = i;
    unique case (state)
      S_P1_DIV: begin
        div_req.start = 1'b1;
      end
      S_MX_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = c_div;
      end
      S_P2_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = i + ROOT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  assign limit_ch.ready = (state == S_IDLE);
  assign total_ch.valid = total_valid;
  assign total_ch.total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      pret        <= S_IDLE;
      total_valid <= 1'b0;
    end else begin
      // The done state decides the output valid itself when it hands over.
      if (total_ch.ready && state != S_DONE) begin
        total_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (limit_ch.valid) begin
            n       <= limit_ch.limit;
            acc     <= '0;
            root    <= '0;
            perfect <= 1'b0;
            bidx    <= BIDX_W'(ROOT_BITS - 1);
            if (limit_ch.limit == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SQ_MUL;
            end
          end
        end

        // Square root, one bit per pass.
        S_SQ_MUL: begin
          ma    <= TOTAL_W'(sq_try);
          mb    <= MB_W'(sq_try);
          ret   <= S_SQ_CMP;
          state <= S_MUL_LO;
        end
        S_SQ_CMP: begin
          if (ma <= TOTAL_W'(n)) begin
            root    <= sq_try;
            perfect <= (ma == TOTAL_W'(n));
          end
          if (bidx == '0) begin
            i     <= ROOT_BITS'(1);
            state <= S_P1_DIV;
          end else begin
            bidx  <= bidx - BIDX_W'(1);
            state <= S_SQ_MUL;
          end
        end

        // Shared subroutines.
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state <= ret;
          end
        end
        S_MUL_LO: begin
          prod_lo <= TOTAL_W'(mul_p);
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= mul_p[HALF_W-1:0];
          state   <= S_MUL_ADD;
        end
        S_MUL_ADD: begin
          ma    <= prod_lo + {prod_hi, HALF_W'(0)};
          state <= ret;
        end

        // Direct terms i^2 * (n/i)^3 for i = 1..s.
        S_P1_DIV: begin
          ret   <= S_P1_Q;
          state <= S_DIV_WAIT;
        end
        S_P1_Q: begin
          ma    <= TOTAL_W'(div_rsp.quo);
          mb    <= MB_W'(div_rsp.quo);
          ret   <= S_P1_M2;
          state <= S_MUL_LO;
        end
        S_P1_M2: begin
          ret   <= S_P1_M3;
          state <= S_MUL_LO;
        end
        S_P1_M3: begin
          mb    <= MB_W'(i);
          ret   <= S_P1_M4;
          state <= S_MUL_LO;
        end
        S_P1_M4: begin
          ret   <= S_P1_ACC;
          state <= S_MUL_LO;
        end
        S_P1_ACC: begin
          acc <= acc + ma;
          if (i == root) begin
            state <= S_MX_DIV;
          end else begin
            i     <= i + ROOT_BITS'(1);
            state <= S_P1_DIV;
          end
        end

        // Largest quotient value v, then P(n) to seed the difference chain.
        S_MX_DIV: begin
          ret   <= S_MX_Q;
          state <= S_DIV_WAIT;
        end
        S_MX_Q: begin
          maxv  <= div_rsp.quo;
          pm    <= n;
          pret  <= S_P2_START;
          state <= S_P_DIV3;
        end

        // Sum of squares P(pm), left in ma.
        S_P_DIV3: begin
          p_quo <= third_q;
          p_rem <= third_r;
          state <= S_P_F;
        end
        S_P_F: begin
          ma    <= TOTAL_W'(f0);
          mb    <= f1;
          ret   <= S_P_M2;
          state <= S_MUL_LO;
        end
        S_P_M2: begin
          mb    <= f2;
          ret   <= pret;
          state <= S_MUL_LO;
        end

        // Block terms i^3 * (P(n/i) - P(n/(i+1))) for i = 1..v.
        S_P2_START: begin
          pprev <= ma;
          i     <= ROOT_BITS'(1);
          if (maxv == '0) begin
            state <= S_FIX;
          end else begin
            state <= S_P2_DIV;
          end
        end
        S_P2_DIV: begin
          ret   <= S_P2_Q;
          state <= S_DIV_WAIT;
        end
        S_P2_Q: begin
          pm    <= div_rsp.quo;
          pret  <= S_P2_D;
          state <= S_P_DIV3;
        end
        S_P2_D: begin
          ma    <= pprev - ma;
          pprev <= ma;
          mb    <= MB_W'(i);
          ret   <= S_P2_M2;
          state <= S_MUL_LO;
        end
        S_P2_M2: begin
          ret   <= S_P2_M3;
          state <= S_MUL_LO;
        end
        S_P2_M3: begin
          ret   <= S_P2_ACC;
          state <= S_MUL_LO;
        end
        S_P2_ACC: begin
          acc <= acc + ma;
          if (LIMIT_BITS'(i) == maxv) begin
            state <= S_FIX;
          end else begin
            i     <= i + ROOT_BITS'(1);
            state <= S_P2_DIV;
          end
        end

        // On a perfect square, take out the doubly counted s^5.
        S_FIX: begin
          if (perfect) begin
            ma    <= TOTAL_W'(root);
            mb    <= MB_W'(root);
            ret   <= S_FX_M2;
            state <= S_MUL_LO;
          end else begin
            state <= S_DONE;
          end
        end
        S_FX_M2: begin
          ret   <= S_FX_M3;
          state <= S_MUL_LO;
        end
        S_FX_M3: begin
          ret   <= S_FX_M4;
          state <= S_MUL_LO;
        end
        S_FX_M4: begin
          ret   <= S_FX_SUB;
          state <= S_MUL_LO;
        end
        S_FX_SUB: begin
          acc   <= acc - ma;
          state <= S_DONE;
        end

        // Hand the sum to the output register once it is free.
        S_DONE: begin
          if (!total_valid || total_ch.ready) begin
            total       <= acc;
            total_valid <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_waited : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_WAIT)
    else $error("divider finished while the sequencer was not waiting for it");

  a_div_nonzero : assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_req.divisor != '0)
    else $error("division started with a zero divisor");

  a_p1_index : assert property (@(posedge clk) disable iff (rst)
    state == S_P1_ACC |-> (i != '0 && i <= root))
    else $error("direct-term index left the range 1..s");

  a_out_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(total_valid) |-> $past(state) == S_DONE)
    else $error("output loaded outside the done state");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for floor_quotient_block_power_sum
// Sends summation limits over the limit channel and checks every returned
// total against an in-bench computation of sum x^2 * floor(n/x)^3 mod 2^64.
// Both channels idle in random bursts. Most limits are small so the run stays
// short, and a few reach the top of the 20-bit range.
// ----------------------------------------------------------------------------

// Holds the totals still owed by the block, in the order the limits went in,
// and compares each returned total against the oldest one.
class power_sum_board;
  bit [63:0] pending_totals[$];
  int        limits_seen;
  int        totals_checked;
  int        errors;

  // Sum of squares 1..m. The triple product stays below 2^64 for m < 2^20.
  function bit [63:0] square_sum(bit [63:0] m);
    return (m * (m + 64'd1) * (64'd2 * m + 64'd1)) / 64'd6;
  endfunction

  // Floor-quotient block evaluation of the power sum, wrapping modulo 2^64.
  function bit [63:0] block_power_sum(bit [fqbps_pkg::LIMIT_BITS-1:0] lim);
    bit [63:0] n;
    bit [63:0] acc;
    bit [63:0] root;
    bit [63:0] trial;
    bit [63:0] ceil_root;
    bit [63:0] top_quot;
    bit [63:0] q;
    bit [63:0] i;
    int        b;
    n   = lim;
    acc = 64'd0;
    if (n == 64'd0) begin
      return 64'd0;
    end
    root = 64'd0;
    for (b = (fqbps_pkg::LIMIT_BITS + 1) / 2; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    ceil_root = (root * root == n) ? root : root + 64'd1;
    for (i = 64'd1; i <= root; i++) begin
      q = n / i;
      acc += i * i * (q * q * q);
    end
    top_quot = n / ceil_root;
    for (i = 64'd1; i <= top_quot; i++) begin
      acc += (i * i * i) * (square_sum(n / i) - square_sum(n / (i + 64'd1)));
    end
    // A perfect square has its middle term counted by both loops.
    if (root * root == n) begin
      acc -= (root * root) * (root * root * root);
    end
    return acc;
  endfunction

  function void note_limit(bit [fqbps_pkg::LIMIT_BITS-1:0] lim);
    pending_totals.push_back(block_power_sum(lim));
    limits_seen++;
  endfunction

  function void check_total(bit [63:0] got);
    bit [63:0] want;
    if (pending_totals.size() == 0) begin
      $error("total: expected nothing, actual %0d", got);
      errors++;
      return;
    end
    want = pending_totals.pop_front();
    totals_checked++;
    if (got !== want) begin
      $error("total: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import fqbps_pkg::*;

  // Cycles without any transfer before the run is declared hung. It is set
  // well above the run time of the slowest limit, so this leaves a wide margin.
  localparam int QUIET_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 100;
  // The final stretch of random limits runs with no idling on either side.
  localparam int STEADY_ITEMS = 20;

  logic clk = 1'b0;
  logic rst;

  fqbps_limit_if limit_ch();
  fqbps_total_if total_ch();

  floor_quotient_block_power_sum uut (
    .clk      (clk),
    .rst      (rst),
    .limit_ch (limit_ch),
    .total_ch (total_ch)
  );

  power_sum_board board = new();

  // When clear, neither the sender nor the receiver inserts idle bursts.
  bit idling_on = 1'b1;
  int quiet_cycles = 0;

  // Corner limits: zero (twice in a row, so a second result can finish while
  // the first may still be held), the smallest values, perfect squares and
  // their neighbors, powers of two, and the top of the range.
  bit [LIMIT_BITS-1:0] corner_limits[] = '{
    20'd0, 20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd8, 20'd9, 20'd10,
    20'd15, 20'd16, 20'd17, 20'd63, 20'd64, 20'd65, 20'd1023, 20'd1024,
    20'd4095, 20'd4096, 20'hAAAAA, 20'd1046529, 20'hFFFFF
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both monitors sample in the active region right after the edge, so they
  // see the values that were stable at the edge.
  always @(posedge clk) begin
    if (!rst && limit_ch.valid && limit_ch.ready) begin
      board.note_limit(limit_ch.limit);
    end
    if (!rst && total_ch.valid && total_ch.ready) begin
      board.check_total(total_ch.total);
    end
  end

  // The watchdog restarts on any transfer; a long silence means a hang.
  always @(posedge clk) begin
    if (rst || (limit_ch.valid && limit_ch.ready) || (total_ch.valid && total_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Picks a limit with a random bit width. Most widths are small because the
  // block's run time grows with the square root of the limit; a few limits
  // use the full 20 bits so that every bit is exercised high and low.
  function automatic bit [LIMIT_BITS-1:0] random_limit();
    int        pick;
    int        width;
    bit [31:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      width = $urandom_range(17, LIMIT_BITS);
    end else if (pick < 20) begin
      width = $urandom_range(13, 16);
    end else begin
      width = $urandom_range(1, 12);
    end
    mask = (32'd1 << width) - 32'd1;
    return LIMIT_BITS'($urandom & mask);
  endfunction

  // Presents one limit and returns at the edge where it transfers. Valid stays
  // high on return so that back-to-back limits follow without a gap; a gap, when
  // one is drawn, lowers it first.
  task automatic send_limit(input bit [LIMIT_BITS-1:0] lim);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      limit_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    limit_ch.valid <= 1'b1;
    limit_ch.limit <= lim;
    do @(posedge clk); while (!limit_ch.ready);
  endtask

  // Waits until every outstanding total has come back. The first edge lets
  // the monitor record a limit that transferred at the edge we started on.
  task automatic wait_for_totals();
    do @(posedge clk); while (board.pending_totals.size() != 0);
  endtask

  // The receiver stalls in random bursts while idling is on.
  initial begin
    total_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 5) == 0) begin
        total_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      total_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    rst            <= 1'b1;
    limit_ch.valid <= 1'b0;
    limit_ch.limit <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners first.
    foreach (corner_limits[k]) begin
      send_limit(corner_limits[k]);
    end

    // Hold the sender back until the block has drained completely, so the
    // next limit arrives with an empty output register.
    limit_ch.valid <= 1'b0;
    wait_for_totals();

    // Random limits, with the last stretch sent and received without gaps.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - STEADY_ITEMS) begin
        idling_on = 1'b0;
      end
      send_limit(random_limit());
    end
    limit_ch.valid <= 1'b0;

    // A short tail catches any unexpected extra total.
    wait_for_totals();
    repeat (64) @(posedge clk);

    $display("Run covered %0d limits and checked %0d totals: zero, perfect squares,",
             board.limits_seen, board.totals_checked);
    $display("powers of two, mostly small random limits and a few up to the 20-bit maximum.");
    if (board.errors == 0 && board.pending_totals.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
